[design/sbc_pkg.sv]
// Shared types, constants and helpers for the sphere against box contact core.
// Depends on nothing; sphere_box_contact_core imports it.
package sbc_pkg;

    // Pipeline step counts of the root and quotient sections.
    localparam int unsigned SQRT_STEPS = 31;
    localparam int unsigned DIV_STEPS  = 31;

    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    // Result of one pair as it travels down the pipeline.
    typedef struct packed {
        logic             contact;
        logic             use_div;
        logic [2:0]       nneg;
        logic [2:0]       nunit;
        logic [31:0]      depth;
        logic [2:0][31:0] point;
    } res_t;

    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        logic [31:0] r;
        if (v > 34'sd2147483647)
        begin
            r = 32'h7FFF_FFFF;
        end
        else if (v < -34'sd2147483648)
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[design/sphere_box_contact_core.sv]
// Sphere against axis-aligned box contact core: one fully pipelined datapath.
// Depends on sbc_pkg for the result struct, constants and saturation.
//
// Usage: a pair (sphere center, radius, box center, half extents) enters on the
// slave stream; sphere_first travels in s_tuser and says which body is first.
// Each accepted transaction yields exactly one result transaction on the master
// stream: m_tuser carries the contact flag, m_tdata the normal, depth and point.
// When there is no contact every result field is zero.
//
// Throughput is one pair per clock while the receiver does not stall. The pipeline
// is made of the front stages that clamp, square, sum and normalize, the 31-step
// pipelined square root of the squared distance, the 31-step pipelined divider
// (three lanes) that scales the normal, and the output register.
//
// All stages advance on one enable, which is high when the output register is
// empty or being taken. A stalled receiver therefore freezes the pipeline and
// deasserts s_tready in the same cycle; nothing is lost or repeated.
// Reset clears only the valid bits; the datapath registers carry no reset.
module sphere_box_contact_core
    import sbc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // sphere_x, sphere_y, sphere_z, radius, box_x, box_y, box_z,
    // half_x, half_y, half_z, then four zero bits
    input  logic [319:0] s_tdata,
    // sphere_first
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // normal_x, normal_y, normal_z, depth, point_x, point_y, point_z
    output logic [223:0] m_tdata,
    // contact
    output logic         m_tuser
);

    logic ce;

    // Input field unpacking.
    logic [31:0] in_s [3];
    logic [31:0] in_b [3];
    logic [30:0] in_h [3];
    logic [30:0] in_r;

    assign in_s[0] = s_tdata[31:0];
    assign in_s[1] = s_tdata[63:32];
    assign in_s[2] = s_tdata[95:64];
    assign in_r    = s_tdata[126:96];
    assign in_b[0] = s_tdata[158:127];
    assign in_b[1] = s_tdata[190:159];
    assign in_b[2] = s_tdata[222:191];
    assign in_h[0] = s_tdata[253:223];
    assign in_h[1] = s_tdata[284:254];
    assign in_h[2] = s_tdata[315:285];

    // Stage 1: offset between the centers in the frame of the first body.
    logic               v1_reg;
    logic signed [32:0] d1_reg [3];
    logic [31:0]        b1_reg [3];
    logic [30:0]        h1_reg [3];
    logic [30:0]        rad1_reg;
    logic               f1_reg;

    // Stage 2: clamp to the box, distance outside the box per axis.
    logic               v2_reg;
    logic [31:0]        absd2_reg [3];
    logic [31:0]        c2_reg [3];
    logic [30:0]        magv2_reg [3];
    logic [2:0]         vneg2_reg;
    logic               inside2_reg;
    logic               far2_reg;
    logic [31:0]        b2_reg [3];
    logic [30:0]        h2_reg [3];
    logic [30:0]        rad2_reg;
    logic               f2_reg;

    logic [31:0]        absd2_next [3];
    logic [31:0]        c2_next [3];
    logic [30:0]        magv2_next [3];
    logic [2:0]         ax_in;
    logic [2:0]         far_ax;

    // Stage 3: squares, snap axis for the inside case, contact points.
    logic               v3_reg;
    res_t               res3_reg;
    logic [61:0]        sqv3_reg [3];
    logic [61:0]        rsq3_reg;
    logic [30:0]        magv3_reg [3];
    logic               inside3_reg;
    logic               far3_reg;

    res_t               res3_next;
    logic [1:0]         snap_k;
    logic [30:0]        gap;
    logic               dpos;

    // Stage 4: sum of squares.
    logic               v4_reg;
    res_t               res4_reg;
    logic [63:0]        sq4_reg;
    logic [61:0]        rsq4_reg;
    logic [30:0]        magv4_reg [3];
    logic               inside4_reg;
    logic               far4_reg;

    // Stage 5: range test and normalizing shift count.
    logic               v5_reg;
    res_t               res5_reg;
    logic [61:0]        sq5_reg;
    logic [4:0]         m5_reg;
    logic [30:0]        magv5_reg [3];

    logic               nocontact;
    logic [4:0]         m_next;

    // Square root pipeline; index 0 is loaded with the normalized square.
    logic               q_v_reg    [SQRT_STEPS+1];
    res_t               q_res_reg  [SQRT_STEPS+1];
    logic [61:0]        q_t_reg    [SQRT_STEPS+1];
    logic [32:0]        q_rem_reg  [SQRT_STEPS+1];
    logic [30:0]        q_root_reg [SQRT_STEPS+1];
    logic [4:0]         q_m_reg    [SQRT_STEPS+1];
    logic [2:0][30:0]   q_magm_reg [SQRT_STEPS+1];

    // Divider pipeline; index 0 holds the numerators and the rounded depth.
    logic               dv_v_reg    [DIV_STEPS+1];
    res_t               dv_res_reg  [DIV_STEPS+1];
    logic [30:0]        dv_root_reg [DIV_STEPS+1];
    logic [2:0][60:0]   dv_num_reg  [DIV_STEPS+1];
    logic [2:0][30:0]   dv_rem_reg  [DIV_STEPS+1];
    logic [2:0][30:0]   dv_q_reg    [DIV_STEPS+1];

    logic [31:0]        len_w;
    logic [31:0]        rnd_w;
    res_t               res7_next;

    // Output register.
    logic               out_v_reg;
    logic [223:0]       out_data_reg;
    logic               out_user_reg;
    logic [2:0][31:0]   nrm_next;

    assign ce       = !out_v_reg || m_tready;
    assign s_tready = ce;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // ------------------------------------------------------------------ valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            out_v_reg <= 1'b0;
            for (int i = 0; i <= SQRT_STEPS; i++)
            begin
                q_v_reg[i] <= 1'b0;
            end
            for (int i = 0; i <= DIV_STEPS; i++)
            begin
                dv_v_reg[i] <= 1'b0;
            end
        end
        else if (ce)
        begin
            v1_reg     <= s_tvalid;
            v2_reg     <= v1_reg;
            v3_reg     <= v2_reg;
            v4_reg     <= v3_reg;
            v5_reg     <= v4_reg;
            q_v_reg[0] <= v5_reg;
            for (int i = 1; i <= SQRT_STEPS; i++)
            begin
                q_v_reg[i] <= q_v_reg[i-1];
            end
            dv_v_reg[0] <= q_v_reg[SQRT_STEPS];
            for (int i = 1; i <= DIV_STEPS; i++)
            begin
                dv_v_reg[i] <= dv_v_reg[i-1];
            end
            out_v_reg <= dv_v_reg[DIV_STEPS];
        end
    end

    // ---------------------------------------------------------------- stage 1
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (s_tuser)
                begin
                    d1_reg[a] <= $signed({in_b[a][31], in_b[a]})
                               - $signed({in_s[a][31], in_s[a]});
                end
                else
                begin
                    d1_reg[a] <= $signed({in_s[a][31], in_s[a]})
                               - $signed({in_b[a][31], in_b[a]});
                end
                b1_reg[a] <= in_b[a];
                h1_reg[a] <= in_h[a];
            end
            rad1_reg <= in_r;
            f1_reg   <= s_tuser;
        end
    end

    // ---------------------------------------------------------------- stage 2
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            absd2_next[a] = d1_reg[a][32] ? 32'(-d1_reg[a]) : d1_reg[a][31:0];
            ax_in[a]      = absd2_next[a] <= {1'b0, h1_reg[a]};
            if (ax_in[a])
            begin
                c2_next[a] = d1_reg[a][31:0];
            end
            else if (d1_reg[a][32])
            begin
                c2_next[a] = 32'(-{1'b0, h1_reg[a]});
            end
            else
            begin
                c2_next[a] = {1'b0, h1_reg[a]};
            end
            // Outside the slab the distance past the face is |d| - half.
            if (ax_in[a])
            begin
                far_ax[a]     = 1'b0;
                magv2_next[a] = '0;
            end
            else
            begin
                far_ax[a]     = (absd2_next[a] - {1'b0, h1_reg[a]}) > {1'b0, rad1_reg};
                magv2_next[a] = 31'(absd2_next[a] - {1'b0, h1_reg[a]});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int a = 0; a < 3; a++)
            begin
                absd2_reg[a] <= absd2_next[a];
                c2_reg[a]    <= c2_next[a];
                magv2_reg[a] <= magv2_next[a];
                vneg2_reg[a] <= d1_reg[a][32];
                b2_reg[a]    <= b1_reg[a];
                h2_reg[a]    <= h1_reg[a];
            end
            inside2_reg <= &ax_in;
            far2_reg    <= |far_ax;
            rad2_reg    <= rad1_reg;
            f2_reg      <= f1_reg;
        end
    end

    // ---------------------------------------------------------------- stage 3
    always_comb
    begin
        // Snap axis: strictly smallest |d| wins, ties fall through to z.
        if (absd2_reg[0] < absd2_reg[1] && absd2_reg[0] < absd2_reg[2])
        begin
            snap_k = 2'd0;
        end
        else if (absd2_reg[1] < absd2_reg[0] && absd2_reg[1] < absd2_reg[2])
        begin
            snap_k = 2'd1;
        end
        else
        begin
            snap_k = 2'd2;
        end
        gap  = h2_reg[snap_k] - absd2_reg[snap_k][30:0];
        dpos = !vneg2_reg[snap_k] && (absd2_reg[snap_k] != '0);

        res3_next         = '0;
        res3_next.contact = 1'b1;
        res3_next.use_div = !inside2_reg;
        if (inside2_reg)
        begin
            res3_next.nneg[snap_k]  = !dpos;
            res3_next.nunit[snap_k] = gap != '0;
            res3_next.depth = sat32($signed({3'b000, rad2_reg}) + $signed({3'b000, gap}));
            for (int a = 0; a < 3; a++)
            begin
                res3_next.point[a] = b2_reg[a];
            end
        end
        else
        begin
            // Depth is finished after the root; the radius rides along until then.
            res3_next.nneg  = vneg2_reg;
            res3_next.depth = {1'b0, rad2_reg};
            for (int a = 0; a < 3; a++)
            begin
                if (f2_reg)
                begin
                    res3_next.point[a] = sat32($signed({{2{b2_reg[a][31]}}, b2_reg[a]})
                                             - $signed({{2{c2_reg[a][31]}}, c2_reg[a]}));
                end
                else
                begin
                    res3_next.point[a] = sat32($signed({{2{b2_reg[a][31]}}, b2_reg[a]})
                                             + $signed({{2{c2_reg[a][31]}}, c2_reg[a]}));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            res3_reg <= res3_next;
            for (int a = 0; a < 3; a++)
            begin
                sqv3_reg[a]  <= magv2_reg[a] * magv2_reg[a];
                magv3_reg[a] <= magv2_reg[a];
            end
            rsq3_reg    <= rad2_reg * rad2_reg;
            inside3_reg <= inside2_reg;
            far3_reg    <= far2_reg;
        end
    end

    // ---------------------------------------------------------------- stage 4
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            res4_reg    <= res3_reg;
            sq4_reg     <= {2'b00, sqv3_reg[0]} + {2'b00, sqv3_reg[1]} + {2'b00, sqv3_reg[2]};
            rsq4_reg    <= rsq3_reg;
            magv4_reg   <= magv3_reg;
            inside4_reg <= inside3_reg;
            far4_reg    <= far3_reg;
        end
    end

    // ---------------------------------------------------------------- stage 5
    always_comb
    begin
        nocontact = !inside4_reg && (far4_reg || (sq4_reg > {2'b00, rsq4_reg}));
        // Shift count that brings the top nonzero bit pair to bits 61:60.
        m_next = 5'd30;
        for (int p = 0; p < 31; p++)
        begin
            if (sq4_reg[2*p +: 2] != 2'b00)
            begin
                m_next = 5'(30 - p);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            res5_reg  <= nocontact ? '0 : res4_reg;
            sq5_reg   <= sq4_reg[61:0];
            m5_reg    <= m_next;
            magv5_reg <= magv4_reg;
        end
    end

    // ------------------------------------------------ stage 6: normalize shift
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            q_res_reg[0]  <= res5_reg;
            q_t_reg[0]    <= sq5_reg << {m5_reg, 1'b0};
            q_rem_reg[0]  <= '0;
            q_root_reg[0] <= '0;
            q_m_reg[0]    <= m5_reg;
            for (int a = 0; a < 3; a++)
            begin
                q_magm_reg[0][a] <= magv5_reg[a] << m5_reg;
            end
        end
    end

    // ------------------------------------------- square root, one bit a stage
    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_sqrt
        logic [34:0] rem_w;
        logic [34:0] trial_w;

        assign rem_w   = {q_rem_reg[i], q_t_reg[i][61-2*i -: 2]};
        assign trial_w = {2'b00, q_root_reg[i], 2'b01};

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                q_res_reg[i+1]  <= q_res_reg[i];
                q_t_reg[i+1]    <= q_t_reg[i];
                q_m_reg[i+1]    <= q_m_reg[i];
                q_magm_reg[i+1] <= q_magm_reg[i];
                if (rem_w >= trial_w)
                begin
                    q_rem_reg[i+1]  <= 33'(rem_w - trial_w);
                    q_root_reg[i+1] <= {q_root_reg[i][29:0], 1'b1};
                end
                else
                begin
                    q_rem_reg[i+1]  <= rem_w[32:0];
                    q_root_reg[i+1] <= {q_root_reg[i][29:0], 1'b0};
                end
            end
        end
    end

    // --------------------------------- stage 7: depth and divider numerators
    always_comb
    begin
        rnd_w = (32'd1 << q_m_reg[SQRT_STEPS]) >> 1;
        len_w = ({1'b0, q_root_reg[SQRT_STEPS]} + rnd_w) >> q_m_reg[SQRT_STEPS];
        res7_next = q_res_reg[SQRT_STEPS];
        if (res7_next.use_div)
        begin
            res7_next.depth = sat32($signed({2'b00, res7_next.depth})
                                  - $signed({2'b00, len_w}));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            dv_res_reg[0]  <= res7_next;
            dv_root_reg[0] <= q_root_reg[SQRT_STEPS];
            for (int a = 0; a < 3; a++)
            begin
                // The rounding half of the root fills the low 30 bits exactly.
                dv_num_reg[0][a] <= {q_magm_reg[SQRT_STEPS][a], q_root_reg[SQRT_STEPS][30:1]};
                dv_rem_reg[0][a] <= {1'b0, q_magm_reg[SQRT_STEPS][a][30:1]};
                dv_q_reg[0][a]   <= '0;
            end
        end
    end

    // ------------------------------------- restoring divider, one bit a stage
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        logic [2:0][31:0] rem_w;
        logic [2:0]       ge_w;

        always_comb
        begin
            for (int a = 0; a < 3; a++)
            begin
                rem_w[a] = {dv_rem_reg[i][a], dv_num_reg[i][a][30-i]};
                ge_w[a]  = rem_w[a] >= {1'b0, dv_root_reg[i]};
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                dv_res_reg[i+1]  <= dv_res_reg[i];
                dv_root_reg[i+1] <= dv_root_reg[i];
                dv_num_reg[i+1]  <= dv_num_reg[i];
                for (int a = 0; a < 3; a++)
                begin
                    if (ge_w[a])
                    begin
                        dv_rem_reg[i+1][a] <= 31'(rem_w[a] - {1'b0, dv_root_reg[i]});
                    end
                    else
                    begin
                        dv_rem_reg[i+1][a] <= rem_w[a][30:0];
                    end
                    dv_q_reg[i+1][a] <= {dv_q_reg[i][a][29:0], ge_w[a]};
                end
            end
        end
    end

    // ---------------------------------------------------------- output stage
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            if (dv_res_reg[DIV_STEPS].use_div)
            begin
                nrm_next[a] = ({1'b0, dv_q_reg[DIV_STEPS][a]} > ONE_Q30) ? ONE_Q30
                            : {1'b0, dv_q_reg[DIV_STEPS][a]};
            end
            else if (dv_res_reg[DIV_STEPS].nunit[a])
            begin
                nrm_next[a] = ONE_Q30;
            end
            else
            begin
                nrm_next[a] = '0;
            end
            if (dv_res_reg[DIV_STEPS].nneg[a])
            begin
                nrm_next[a] = 32'(-nrm_next[a]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            out_user_reg <= dv_res_reg[DIV_STEPS].contact;
            out_data_reg <= {dv_res_reg[DIV_STEPS].point[2], dv_res_reg[DIV_STEPS].point[1],
                             dv_res_reg[DIV_STEPS].point[0], dv_res_reg[DIV_STEPS].depth,
                             nrm_next[2], nrm_next[1], nrm_next[0]};
        end
    end

    // ------------------------------------------------------------- assertions
    a_no_contact_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("result without contact carries nonzero fields");

    a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[31:0]) <= $signed(ONE_Q30))
                  && ($signed(m_tdata[31:0]) >= -$signed(ONE_Q30))
                  && ($signed(m_tdata[63:32]) <= $signed(ONE_Q30))
                  && ($signed(m_tdata[63:32]) >= -$signed(ONE_Q30))
                  && ($signed(m_tdata[95:64]) <= $signed(ONE_Q30))
                  && ($signed(m_tdata[95:64]) >= -$signed(ONE_Q30)))
        else $error("normal component beyond unit length");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !ce |=> $stable({v1_reg, v2_reg, v3_reg, v4_reg, v5_reg,
                         q_v_reg[SQRT_STEPS], dv_v_reg[DIV_STEPS]}))
        else $error("pipeline moved while the output was stalled");

endmodule
